// ===== rtl/ptrot_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrot_pkg
// Shared types, constants and fixed-point helpers for the point rotation block.
// ----------------------------------------------------------------------------
package ptrot_pkg;

    localparam int COORD_BITS     = 32;
    localparam int ANGLE_BITS     = 16;
    localparam int PHASE_BITS     = 32;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 34;
    localparam int ZW           = 32;
    localparam int Q15_BITS     = 16;
    localparam int Q15_FRAC     = 15;
    localparam int COEF_BITS    = Q15_BITS + 1;

    localparam int PROD_W = COEF_BITS + COORD_BITS;
    localparam int TERM_W = PROD_W - Q15_FRAC;
    localparam int SUM_W  = TERM_W + 2;

    localparam int PROD_COUNT = 4;
    localparam int PIDX_BITS  = $clog2(PROD_COUNT);

    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(CORDIC_STEPS - 1);
    localparam logic [PIDX_BITS-1:0] PIDX_LAST = PIDX_BITS'(PROD_COUNT - 1);

    // product select codes in the coefficient sequencer
    localparam logic [PIDX_BITS-1:0] PIDX_SA_CG = 2'd0;
    localparam logic [PIDX_BITS-1:0] PIDX_SA_SG = 2'd1;
    localparam logic [PIDX_BITS-1:0] PIDX_CA_CG = 2'd2;
    localparam logic [PIDX_BITS-1:0] PIDX_CA_SG = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_Z = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_X = CFG_INDEX_BITS'(1);

    // quadrant codes from the top two angle bits
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
    localparam logic signed [CORDIC_W-1:0] ROUND_C     = CORDIC_W'(16384);
    localparam logic signed [CORDIC_W-1:0] Q15_MAX_C   = CORDIC_W'(32767);
    localparam logic signed [CORDIC_W-1:0] Q15_MIN_C   = -CORDIC_W'(32768);
    localparam logic signed [Q15_BITS-1:0] Q15_MAX     = Q15_BITS'(32767);
    localparam logic signed [Q15_BITS-1:0] Q15_MIN     = {1'b1, {(Q15_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]   ROUND_P     = PROD_W'(16384);

    localparam logic signed [SUM_W-1:0] COORD_MAX =
        {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] COORD_MIN =
        {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    // atan(2^-i), 2^32 units per turn
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    typedef enum logic [2:0] {
        CS_LOAD_Z,
        CS_ITER_Z,
        CS_FIN_Z,
        CS_ITER_X,
        CS_FIN_X,
        CS_PROD,
        CS_DONE
    } coef_state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] in_x;
        logic signed [COORD_BITS-1:0] in_y;
        logic signed [COORD_BITS-1:0] in_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic                         saturated;
    } out_item_t;

    // rotation matrix, Q1.15 with one extra bit for negated -1.0
    typedef struct packed {
        logic signed [COEF_BITS-1:0] m00;
        logic signed [COEF_BITS-1:0] m01;
        logic signed [COEF_BITS-1:0] m02;
        logic signed [COEF_BITS-1:0] m10;
        logic signed [COEF_BITS-1:0] m11;
        logic signed [COEF_BITS-1:0] m12;
        logic signed [COEF_BITS-1:0] m21;
        logic signed [COEF_BITS-1:0] m22;
    } coef_t;

    // round half up to Q1.15 and clip
    function automatic logic signed [Q15_BITS-1:0] round_q15(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] t;
        t = v + ROUND_C;
        t = t >>> Q15_FRAC;
        if (t > Q15_MAX_C)
            return Q15_MAX;
        else if (t < Q15_MIN_C)
            return Q15_MIN;
        else
            return Q15_BITS'(t);
    endfunction

    // negate with clip of -1.0
    function automatic logic signed [Q15_BITS-1:0] neg_sat_q15(
        input logic signed [Q15_BITS-1:0] v
    );
        if (v == Q15_MIN)
            return Q15_MAX;
        else
            return -v;
    endfunction

    // coordinate times coefficient, rounded back to Q16.16
    function automatic logic signed [TERM_W-1:0] round_term(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = p + ROUND_P;
        t = t >>> Q15_FRAC;
        return TERM_W'(t);
    endfunction

    function automatic logic coord_ovf(input logic signed [SUM_W-1:0] s);
        return (s > COORD_MAX) || (s < COORD_MIN);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] coord_sat(
        input logic signed [SUM_W-1:0] s
    );
        if (s > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        else if (s < COORD_MIN)
            return COORD_BITS'(COORD_MIN);
        else
            return COORD_BITS'(s);
    endfunction

endpackage

// ===== rtl/ptrot_coef.sv =====
// ----------------------------------------------------------------------------
// ptrot_coef
// Angle registers and coefficient sequencer: one shared CORDIC works sine and
// cosine of both angles, then four rounded products form the matrix.
// ----------------------------------------------------------------------------
module ptrot_coef (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ptrot_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ptrot_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output ptrot_pkg::coef_t                      coef,
    output logic                                  busy
);
    import ptrot_pkg::*;

    coef_state_t state_reg, state_next;

    logic [ANGLE_BITS-1:0]       angle_z_reg, angle_x_reg;
    logic [STEP_BITS-1:0]        step_reg;
    logic [PIDX_BITS-1:0]        pidx_reg;
    logic signed [CORDIC_W-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]        z_reg;
    logic signed [Q15_BITS-1:0]  ca_reg, sa_reg, cg_reg, sg_reg;
    coef_t                       coef_reg;

    logic                        cfg_write, cfg_hit;
    logic                        iterate, load_init;
    logic [ANGLE_BITS-1:0]       init_angle, fin_angle;
    logic signed [ZW-1:0]        z_init;
    logic signed [CORDIC_W-1:0]  dx, dy, x_step, y_step;
    logic signed [ZW-1:0]        z_step;
    logic                        rot_pos;
    logic signed [Q15_BITS-1:0]  cq, sq, c_fin, s_fin;
    logic [1:0]                  quad;
    logic signed [Q15_BITS-1:0]  op_a, op_b;
    logic signed [CORDIC_W-1:0]  prod;
    logic signed [Q15_BITS-1:0]  prod_q15;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_write && ((cfg_index == REG_ANGLE_Z) || (cfg_index == REG_ANGLE_X));
    assign coef      = coef_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_LOAD_Z: state_next = CS_ITER_Z;
            CS_ITER_Z:
            begin
                if (step_reg == STEP_LAST)
                    state_next = CS_FIN_Z;
            end
            CS_FIN_Z:  state_next = CS_ITER_X;
            CS_ITER_X:
            begin
                if (step_reg == STEP_LAST)
                    state_next = CS_FIN_X;
            end
            CS_FIN_X:  state_next = CS_PROD;
            CS_PROD:
            begin
                if (pidx_reg == PIDX_LAST)
                    state_next = CS_DONE;
            end
            CS_DONE:   state_next = CS_DONE;
            default:   state_next = CS_LOAD_Z;
        endcase
        if (cfg_hit)
            state_next = CS_LOAD_Z;
    end

    // state outputs
    always_comb
    begin
        busy      = 1'b1;
        iterate   = 1'b0;
        load_init = 1'b0;
        case (state_reg)
            CS_LOAD_Z, CS_FIN_Z: load_init = 1'b1;
            CS_ITER_Z, CS_ITER_X: iterate  = 1'b1;
            CS_DONE:              busy     = 1'b0;
            default:              busy     = 1'b1;
        endcase
    end

    // CORDIC step, rotation mode
    always_comb
    begin
        init_angle = (state_reg == CS_LOAD_Z) ? angle_z_reg : angle_x_reg;
        z_init     = ZW'({init_angle[ANGLE_BITS-3:0], {(PHASE_BITS-ANGLE_BITS){1'b0}}});
        dx         = y_reg >>> step_reg;
        dy         = x_reg >>> step_reg;
        rot_pos    = !z_reg[ZW-1];
        if (rot_pos)
        begin
            x_step = x_reg - dx;
            y_step = y_reg + dy;
            z_step = z_reg - ATAN_TAB[step_reg];
        end
        else
        begin
            x_step = x_reg + dx;
            y_step = y_reg - dy;
            z_step = z_reg + ATAN_TAB[step_reg];
        end
    end

    // quadrant fold of the finished CORDIC result
    always_comb
    begin
        fin_angle = (state_reg == CS_FIN_Z) ? angle_z_reg : angle_x_reg;
        quad      = fin_angle[ANGLE_BITS-1 -: 2];
        cq        = round_q15(x_reg);
        sq        = round_q15(y_reg);
        case (quad)
            QUAD_0:
            begin
                c_fin = cq;
                s_fin = sq;
            end
            QUAD_1:
            begin
                c_fin = neg_sat_q15(sq);
                s_fin = cq;
            end
            QUAD_2:
            begin
                c_fin = neg_sat_q15(cq);
                s_fin = neg_sat_q15(sq);
            end
            default:
            begin
                c_fin = sq;
                s_fin = neg_sat_q15(cq);
            end
        endcase
    end

    // one Q1.15 product per cycle
    always_comb
    begin
        op_a     = pidx_reg[1] ? ca_reg : sa_reg;
        op_b     = pidx_reg[0] ? sg_reg : cg_reg;
        prod     = CORDIC_W'(op_a) * CORDIC_W'(op_b);
        prod_q15 = round_q15(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CS_LOAD_Z;
            angle_z_reg <= '0;
            angle_x_reg <= '0;
            step_reg    <= '0;
            pidx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (cfg_index == REG_ANGLE_Z))
                angle_z_reg <= cfg_data[ANGLE_BITS-1:0];
            if (cfg_write && (cfg_index == REG_ANGLE_X))
                angle_x_reg <= cfg_data[ANGLE_BITS-1:0];
            if (load_init)
                step_reg <= '0;
            else if (iterate)
                step_reg <= step_reg + 1'b1;
            if (state_reg == CS_FIN_X)
                pidx_reg <= '0;
            else if (state_reg == CS_PROD)
                pidx_reg <= pidx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_init)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= z_init;
        end
        else if (iterate)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
        if (state_reg == CS_FIN_Z)
        begin
            ca_reg <= c_fin;
            sa_reg <= s_fin;
        end
        if (state_reg == CS_FIN_X)
        begin
            cg_reg <= c_fin;
            sg_reg <= s_fin;
        end
        if (state_reg == CS_PROD)
        begin
            case (pidx_reg)
                PIDX_SA_CG:
                begin
                    coef_reg.m00 <= COEF_BITS'(ca_reg);
                    coef_reg.m10 <= COEF_BITS'(sa_reg);
                    coef_reg.m21 <= COEF_BITS'(sg_reg);
                    coef_reg.m22 <= COEF_BITS'(cg_reg);
                    coef_reg.m01 <= -COEF_BITS'(prod_q15);
                end
                PIDX_SA_SG: coef_reg.m02 <= COEF_BITS'(prod_q15);
                PIDX_CA_CG: coef_reg.m11 <= COEF_BITS'(prod_q15);
                PIDX_CA_SG: coef_reg.m12 <= -COEF_BITS'(prod_q15);
                default:    coef_reg.m12 <= -COEF_BITS'(prod_q15);
            endcase
        end
    end

`ifndef SYNTHESIS
    a_iter_z_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_ITER_Z && step_reg == STEP_LAST && !cfg_hit)
        |=> (state_reg == CS_FIN_Z))
        else $error("CORDIC pass for z angle did not finish after last step");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (state_reg == CS_LOAD_Z && busy))
        else $error("angle write did not restart coefficient sequence");

    a_prod_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_PROD && pidx_reg == PIDX_LAST && !cfg_hit) |=> !busy)
        else $error("coefficients not ready after last product");
`endif

endmodule

// ===== rtl/ptrot_datapath.sv =====
// ----------------------------------------------------------------------------
// ptrot_datapath
// Point pipeline: input register, product register, rounded sum with saturation
// into the result register. Each stage holds while the next is full and held.
// ----------------------------------------------------------------------------
module ptrot_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptrot_pkg::coef_t      coef,
    input  logic                  coef_busy,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ptrot_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ptrot_pkg::out_item_t  out_data
);
    import ptrot_pkg::*;

    logic                      in_valid_reg, mul_valid_reg, out_valid_reg;
    in_item_t                  in_item_reg;
    out_item_t                 out_item_reg, out_item_next;
    logic signed [PROD_W-1:0]  p00_reg, p01_reg, p02_reg;
    logic signed [PROD_W-1:0]  p10_reg, p11_reg, p12_reg;
    logic signed [PROD_W-1:0]  p21_reg, p22_reg;

    logic                      en_in, en_mul, en_out;
    logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;

    assign en_out    = !out_valid_reg || !out_stall;
    assign en_mul    = !mul_valid_reg || en_out;
    assign en_in     = !in_valid_reg || en_mul;
    assign in_stall  = coef_busy || !en_in;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        sum_x = SUM_W'(round_term(p00_reg)) + SUM_W'(round_term(p01_reg))
              + SUM_W'(round_term(p02_reg));
        sum_y = SUM_W'(round_term(p10_reg)) + SUM_W'(round_term(p11_reg))
              + SUM_W'(round_term(p12_reg));
        // bottom row has no x term
        sum_z = SUM_W'(round_term(p21_reg)) + SUM_W'(round_term(p22_reg));
        out_item_next.out_x     = coord_sat(sum_x);
        out_item_next.out_y     = coord_sat(sum_y);
        out_item_next.out_z     = coord_sat(sum_z);
        out_item_next.saturated = coord_ovf(sum_x) | coord_ovf(sum_y) | coord_ovf(sum_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_in)
                in_valid_reg <= in_valid && !coef_busy;
            if (en_mul)
                mul_valid_reg <= in_valid_reg;
            if (en_out)
                out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
            in_item_reg <= in_data;
        if (en_mul)
        begin
            p00_reg <= PROD_W'($signed(coef.m00)) * PROD_W'($signed(in_item_reg.in_x));
            p01_reg <= PROD_W'($signed(coef.m01)) * PROD_W'($signed(in_item_reg.in_y));
            p02_reg <= PROD_W'($signed(coef.m02)) * PROD_W'($signed(in_item_reg.in_z));
            p10_reg <= PROD_W'($signed(coef.m10)) * PROD_W'($signed(in_item_reg.in_x));
            p11_reg <= PROD_W'($signed(coef.m11)) * PROD_W'($signed(in_item_reg.in_y));
            p12_reg <= PROD_W'($signed(coef.m12)) * PROD_W'($signed(in_item_reg.in_z));
            p21_reg <= PROD_W'($signed(coef.m21)) * PROD_W'($signed(in_item_reg.in_y));
            p22_reg <= PROD_W'($signed(coef.m22)) * PROD_W'($signed(in_item_reg.in_z));
        end
        if (en_out)
            out_item_reg <= out_item_next;
    end

`ifndef SYNTHESIS
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        coef_busy |-> in_stall)
        else $error("input open while coefficients are being worked");

    a_mul_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid_reg && out_valid_reg && out_stall) |=> mul_valid_reg)
        else $error("product stage dropped an item under output stall");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_valid_reg)
        else $error("accepted item not captured in input register");
`endif

endmodule

// ===== rtl/point_rotation_two_angle.sv =====
// ----------------------------------------------------------------------------
// point_rotation_two_angle
// Rotates Q16.16 points by Rz(alpha) * Rx(gamma), with saturation flag.
//
// Channels: in_valid/in_stall/in_data carry one point per item; out_valid/
// out_stall/out_data return the rotated point and the saturated flag. An item
// moves at a clock edge with valid high and stall low. cfg_valid/cfg_ready
// write angle_about_z (index 0) or angle_about_x (index 1); other indexes are
// dropped. cfg_ready is always high.
// Throughput: one item per cycle unless out_stall or the sequencer holds it up.
// A taken item passes the input, product and result registers in order.
// Reset and angle writes: the coefficient sequencer runs one shared CORDIC for
// 16 steps per angle, then forms four products, and holds in_stall high
// meanwhile. After reset both angles are zero.
// Stall: full stages hold in place while out_stall is high; bubbles close up,
// so out_stall raises in_stall only once all stages are full.
// ----------------------------------------------------------------------------
module point_rotation_two_angle (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  ptrot_pkg::in_item_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output ptrot_pkg::out_item_t                  out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ptrot_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ptrot_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ptrot_pkg::*;

    coef_t coef;
    logic  coef_busy;

    ptrot_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .busy      (coef_busy)
    );

    ptrot_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .coef_busy (coef_busy),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
